FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the grant scheduler
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define SRPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle
`define SRPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/srpt_pkg.sv
// ---------------------------------------------------------------------------
// srpt_pkg
// types, codes and sizes of the grant scheduler
// ---------------------------------------------------------------------------
package srpt_pkg;

  localparam int ACTIVE_DEPTH_DEF = 32;
  localparam int WAIT_DEPTH_DEF   = 16;
  localparam int MAX_RESULTS      = 16;
  localparam int KW               = $clog2(MAX_RESULTS);
  localparam int PADDR_W          = 3;

  localparam logic [1:0] FUNC_ENQ    = 2'd0;
  localparam logic [1:0] FUNC_DRAIN  = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_PARKED   = 3'd1;
  localparam logic [2:0] ST_ENQUEUED = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_REMOVED  = 3'd5;
  localparam logic [2:0] ST_NOT_ACT  = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  localparam logic REG_HW_LEVELS    = 1'b0;
  localparam logic REG_UNSCH_LEVELS = 1'b1;

  localparam logic [3:0] HW_LEVELS_RST    = 4'd8;
  localparam logic [2:0] UNSCH_LEVELS_RST = 3'd1;
  localparam logic [3:0] MAX_AVAIL        = 4'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] flow_id;
    logic [31:0] flow_size;
    logic [47:0] start_ticks;
  } req_t;

  typedef struct packed {
    logic [15:0] result_flow_id;
    logic [2:0]  grant_priority;
    logic [2:0]  status;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] size;
    logic [47:0] start;
  } entry_t;

endpackage

FILE: design/srpt_ram.sv
// ---------------------------------------------------------------------------
// srpt_ram
// one write port, one registered read port
// ---------------------------------------------------------------------------
module srpt_ram #(
  parameter int W     = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/srpt_grant_priority_scheduler.sv
// ---------------------------------------------------------------------------
// srpt_grant_priority_scheduler
// enqueue: scans the waitlist, skipped when the waitlist is empty
// remove: walks the active table; drain of an empty waitlist: one empty word
// drain: each flow admitted takes two walks of the active table through
// one compare unit and one ram read port
// not ready while an item is worked; one word per result
// synchronous reset clears valid bits, waitlist pointers and config
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srpt_grant_priority_scheduler #(
  parameter int ACTIVE_DEPTH = srpt_pkg::ACTIVE_DEPTH_DEF,
  parameter int WAIT_DEPTH   = srpt_pkg::WAIT_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srpt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  srpt_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output srpt_pkg::rsp_t               rsp
);
  import srpt_pkg::*;

  localparam int AW  = $clog2(ACTIVE_DEPTH);
  localparam int NW  = $clog2(ACTIVE_DEPTH + 1);
  localparam int WAW = $clog2(WAIT_DEPTH);
  localparam int CW  = $clog2(WAIT_DEPTH + 1);
  localparam int PW  = (NW > 4 ? NW : 4) + 1;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ENQ_SCAN  = 4'd1;
  localparam logic [3:0] S_RM_SCAN   = 4'd2;
  localparam logic [3:0] S_HEAD_RD   = 4'd3;
  localparam logic [3:0] S_HEAD_WAIT = 4'd4;
  localparam logic [3:0] S_SLOT_SCAN = 4'd5;
  localparam logic [3:0] S_WRITE     = 4'd6;
  localparam logic [3:0] S_RANK_SCAN = 4'd7;
  localparam logic [3:0] S_FLUSH     = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;
  localparam logic [3:0] S_PARK      = 4'd10;
  localparam logic [3:0] S_EMIT      = 4'd11;

  logic [3:0] state;
  logic [3:0] scan_kind;

  logic [3:0] hw_levels;
  logic [2:0] unsch_levels;

  logic [ACTIVE_DEPTH-1:0] valid;
  logic [WAW-1:0]          wait_head;
  logic [CW-1:0]           wait_count;

  entry_t         cur;
  logic [AW-1:0]  aidx;
  logic [WAW-1:0] widx;
  logic           p_valid;
  logic [AW-1:0]  p_idx;
  logic           hit;
  logic [AW-1:0]  hit_slot;
  logic           free_found;
  logic [AW-1:0]  free_slot;
  logic [AW-1:0]  slot;
  logic [NW-1:0]  n_act;
  logic [NW-1:0]  rank;
  logic [KW-1:0]  k;

  logic [15:0] em_id;
  logic [2:0]  em_prio;
  logic [2:0]  em_status;
  logic        em_last;

  entry_t         act_rdata;
  entry_t         wait_rdata;
  logic           act_we;
  logic           wait_we;
  logic [WAW-1:0] wait_raddr;
  logic [WAW-1:0] wait_tail;
  logic [WAW:0]   scan_sum;
  logic [CW:0]    tail_sum;
  logic [3:0]     avail;
  logic [PW-1:0]  prio_fit;
  logic           cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_UNSCH_LEVELS) ? {29'd0, unsch_levels} : {28'd0, hw_levels};

  always_ff @(posedge clk) begin
    if (rst) begin
      hw_levels    <= HW_LEVELS_RST;
      unsch_levels <= UNSCH_LEVELS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_UNSCH_LEVELS) begin
        unsch_levels <= pwdata[2:0];
      end else begin
        hw_levels <= pwdata[3:0];
      end
    end
  end

  // waitlist addressing
  assign scan_sum   = {1'b0, wait_head} + {1'b0, widx};
  assign wait_raddr = (scan_sum >= (WAW+1)'(WAIT_DEPTH)) ?
                      WAW'(scan_sum - (WAW+1)'(WAIT_DEPTH)) : WAW'(scan_sum);
  assign tail_sum   = (CW+1)'(wait_head) + (CW+1)'(wait_count);
  assign wait_tail  = (tail_sum >= (CW+1)'(WAIT_DEPTH)) ?
                      WAW'(tail_sum - (CW+1)'(WAIT_DEPTH)) : WAW'(tail_sum);

  assign act_we  = (state == S_WRITE);
  assign wait_we = (state == S_PARK) ||
                   (state == S_DONE && scan_kind == S_ENQ_SCAN && !hit &&
                    wait_count != CW'(WAIT_DEPTH));

  srpt_ram #(.W($bits(entry_t)), .DEPTH(ACTIVE_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (slot),
    .wdata (cur),
    .raddr (aidx),
    .rdata (act_rdata)
  );

  srpt_ram #(.W($bits(entry_t)), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wait_tail),
    .wdata (cur),
    .raddr (wait_raddr),
    .rdata (wait_rdata)
  );

  // available levels and scheduled priority
  always_comb begin
    if (hw_levels <= {1'b0, unsch_levels}) begin
      avail = 4'd0;
    end else if (hw_levels - {1'b0, unsch_levels} > MAX_AVAIL) begin
      avail = MAX_AVAIL;
    end else begin
      avail = hw_levels - {1'b0, unsch_levels};
    end
    prio_fit = PW'(avail) - PW'(n_act) + PW'(rank);
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_kind  <= S_IDLE;
      valid      <= '0;
      wait_head  <= '0;
      wait_count <= '0;
      p_valid    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == S_EMIT && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      p_valid <= (state == S_ENQ_SCAN) || (state == S_RM_SCAN) ||
                 (state == S_SLOT_SCAN) || (state == S_RANK_SCAN);
      p_idx   <= aidx;

      // compare unit on the word read in the previous cycle
      if (p_valid) begin
        case (scan_kind)
          S_ENQ_SCAN: begin
            if (wait_rdata.id == cur.id) begin
              hit <= 1'b1;
            end
          end
          S_RM_SCAN: begin
            if (valid[p_idx] && act_rdata.id == cur.id) begin
              valid[p_idx] <= 1'b0;
              hit          <= 1'b1;
            end
          end
          S_SLOT_SCAN: begin
            if (valid[p_idx] && act_rdata.id == cur.id && !hit) begin
              hit      <= 1'b1;
              hit_slot <= p_idx;
            end
            if (!valid[p_idx] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= p_idx;
            end
          end
          S_RANK_SCAN: begin
            if (valid[p_idx]) begin
              n_act <= n_act + NW'(1);
              if (p_idx != slot &&
                  {act_rdata.size, act_rdata.start, act_rdata.id} <
                  {cur.size, cur.start, cur.id}) begin
                rank <= rank + NW'(1);
              end
            end
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur.id    <= req.flow_id;
            cur.size  <= req.flow_size;
            cur.start <= req.start_ticks;
            hit       <= 1'b0;
            aidx      <= '0;
            widx      <= '0;
            k         <= '0;
            case (req.func)
              FUNC_ENQ: begin
                scan_kind <= S_ENQ_SCAN;
                state     <= (wait_count == '0) ? S_DONE : S_ENQ_SCAN;
              end
              FUNC_REMOVE: begin
                scan_kind <= S_RM_SCAN;
                state     <= S_RM_SCAN;
              end
              FUNC_DRAIN: begin
                if (wait_count == '0) begin
                  em_id     <= '0;
                  em_prio   <= '0;
                  em_status <= ST_EMPTY;
                  em_last   <= 1'b1;
                  state     <= S_EMIT;
                end else begin
                  state <= S_HEAD_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_ENQ_SCAN: begin
          widx <= widx + WAW'(1);
          if (CW'(widx) == wait_count - CW'(1)) begin
            state <= S_FLUSH;
          end
        end
        S_RM_SCAN, S_SLOT_SCAN, S_RANK_SCAN: begin
          if (aidx == AW'(ACTIVE_DEPTH - 1)) begin
            state <= S_FLUSH;
          end else begin
            aidx <= aidx + AW'(1);
          end
        end
        S_HEAD_RD: begin
          state <= S_HEAD_WAIT;
        end
        S_HEAD_WAIT: begin
          cur        <= wait_rdata;
          wait_head  <= (wait_head == WAW'(WAIT_DEPTH - 1)) ? '0 : wait_head + WAW'(1);
          wait_count <= wait_count - CW'(1);
          hit        <= 1'b0;
          free_found <= 1'b0;
          aidx       <= '0;
          scan_kind  <= S_SLOT_SCAN;
          state      <= S_SLOT_SCAN;
        end
        S_FLUSH: begin
          state <= S_DONE;
        end
        S_DONE: begin
          em_id   <= cur.id;
          em_prio <= '0;
          em_last <= 1'b1;
          case (scan_kind)
            S_ENQ_SCAN: begin
              if (hit) begin
                em_status <= ST_DUP;
              end else if (wait_count == CW'(WAIT_DEPTH)) begin
                em_status <= ST_FULL;
              end else begin
                wait_count <= wait_count + CW'(1);
                em_status  <= ST_ENQUEUED;
              end
              state <= S_EMIT;
            end
            S_RM_SCAN: begin
              em_status <= hit ? ST_REMOVED : ST_NOT_ACT;
              state     <= S_EMIT;
            end
            S_SLOT_SCAN: begin
              if (hit) begin
                slot  <= hit_slot;
                state <= S_WRITE;
              end else if (free_found) begin
                slot  <= free_slot;
                state <= S_WRITE;
              end else begin
                state <= S_PARK;
              end
            end
            default: begin
              if (PW'(n_act) <= PW'(avail)) begin
                em_prio   <= prio_fit[2:0];
                em_status <= ST_GRANTED;
                em_last   <= (wait_count == '0) || (k == KW'(MAX_RESULTS - 1));
                state     <= S_EMIT;
              end else if (PW'(rank) < PW'(avail)) begin
                em_prio   <= rank[2:0];
                em_status <= ST_GRANTED;
                em_last   <= (wait_count == '0) || (k == KW'(MAX_RESULTS - 1));
                state     <= S_EMIT;
              end else begin
                valid[slot] <= 1'b0;
                state       <= S_PARK;
              end
            end
          endcase
        end
        S_WRITE: begin
          valid[slot] <= 1'b1;
          n_act       <= '0;
          rank        <= '0;
          aidx        <= '0;
          scan_kind   <= S_RANK_SCAN;
          state       <= S_RANK_SCAN;
        end
        S_PARK: begin
          wait_count <= wait_count + CW'(1);
          em_id      <= cur.id;
          em_prio    <= '0;
          em_status  <= ST_PARKED;
          em_last    <= 1'b1;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.result_flow_id <= em_id;
            rsp.grant_priority <= em_prio;
            rsp.status         <= em_status;
            rsp.last           <= em_last;
            k                  <= k + KW'(1);
            state              <= em_last ? S_IDLE : S_HEAD_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SRPT_ASSERT_IMP(a_wait_bound, 1'b1, wait_count <= CW'(WAIT_DEPTH), "waitlist count over depth")
  `SRPT_ASSERT_IMP(a_park_last, rsp_valid && rsp.status == ST_PARKED, rsp.last, "parked word not last")
  `SRPT_ASSERT_IMP(a_prio_zero, rsp_valid && rsp.status != ST_GRANTED, rsp.grant_priority == 3'd0, "priority on non-grant word")
  `SRPT_ASSERT_NXT(a_busy, req_valid && req_ready && req.func != FUNC_UNUSED, !req_ready, "ready right after item")

endmodule

FILE: verif/tb_srpt_grant_priority_scheduler.sv
// ---------------------------------------------------------------------------
// tb_srpt_grant_priority_scheduler
// drives enqueue, drain and remove words with random gaps and stalls, keeps
// its own model of the waitlist and the active table, and compares every
// result word field by field against the predicted grant or status
// ---------------------------------------------------------------------------
module tb_srpt_grant_priority_scheduler;
  import srpt_pkg::*;

  localparam int ADEPTH = ACTIVE_DEPTH_DEF;
  localparam int WDEPTH = WAIT_DEPTH_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int errors = 0;
  int hold_off = 0;
  bit rsp_random = 1'b1;
  int key_space = 40;

  srpt_grant_priority_scheduler DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  class grant_scoreboard;
    logic [3:0] hw_levels;
    logic [2:0] unsch_levels;
    bit act_v[ADEPTH];
    entry_t act[ADEPTH];
    entry_t wl[$];
    rsp_t pending[$];

    function void clear();
      hw_levels = HW_LEVELS_RST;
      unsch_levels = UNSCH_LEVELS_RST;
      foreach (act_v[i]) act_v[i] = 1'b0;
      wl.delete();
      pending.delete();
    endfunction

    function void add(logic [15:0] id, logic [2:0] prio, logic [2:0] st);
      rsp_t r;
      r.result_flow_id = id;
      r.grant_priority = prio;
      r.status = st;
      r.last = 1'b0;
      pending = {pending, r};
    endfunction

    function bit ranks_lower(entry_t a, entry_t b);
      if (a.size != b.size) return a.size < b.size;
      if (a.start != b.start) return a.start < b.start;
      return a.id < b.id;
    endfunction

    // returns -1 when the flow gets no level
    function int grant_level(entry_t e);
      int slot, n, rank, avail;
      slot = -1;
      n = 0;
      rank = 0;
      for (int i = 0; i < ADEPTH; i++)
        if (slot < 0 && act_v[i] && act[i].id == e.id) slot = i;
      for (int i = 0; i < ADEPTH; i++)
        if (slot < 0 && !act_v[i]) slot = i;
      if (slot < 0) return -1;
      act_v[slot] = 1'b1;
      act[slot] = e;
      for (int i = 0; i < ADEPTH; i++)
        if (act_v[i]) begin
          n++;
          if (i != slot && ranks_lower(act[i], e)) rank++;
        end
      avail = int'(hw_levels) - int'(unsch_levels);
      if (avail < 0) avail = 0;
      if (avail > int'(MAX_AVAIL)) avail = int'(MAX_AVAIL);
      if (n <= avail) return avail - n + rank;
      if (rank < avail) return rank;
      act_v[slot] = 1'b0;
      return -1;
    endfunction

    function void note_request(req_t q);
      int k0, lvl;
      bit dup, found;
      entry_t e;
      k0 = pending.size();
      case (q.func)
        FUNC_ENQ: begin
          dup = 1'b0;
          foreach (wl[i]) if (wl[i].id == q.flow_id) dup = 1'b1;
          if (dup) add(q.flow_id, 3'd0, ST_DUP);
          else if (wl.size() >= WDEPTH) add(q.flow_id, 3'd0, ST_FULL);
          else begin
            e.id = q.flow_id;
            e.size = q.flow_size;
            e.start = q.start_ticks;
            wl = {wl, e};
            add(q.flow_id, 3'd0, ST_ENQUEUED);
          end
        end
        FUNC_DRAIN: begin
          if (wl.size() == 0) add(16'd0, 3'd0, ST_EMPTY);
          while (wl.size() > 0 && pending.size() - k0 < MAX_RESULTS) begin
            e = wl[0];
            wl.delete(0);
            lvl = grant_level(e);
            if (lvl < 0) begin
              wl = {wl, e};
              add(e.id, 3'd0, ST_PARKED);
              break;
            end
            add(e.id, lvl[2:0], ST_GRANTED);
          end
        end
        FUNC_REMOVE: begin
          found = 1'b0;
          for (int i = 0; i < ADEPTH; i++)
            if (act_v[i] && act[i].id == q.flow_id) begin
              act_v[i] = 1'b0;
              found = 1'b1;
            end
          add(q.flow_id, 3'd0, found ? ST_REMOVED : ST_NOT_ACT);
        end
        default: ;
      endcase
      if (pending.size() > k0) pending[$].last = 1'b1;
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending[0];
      pending.delete(0);
      if (got.result_flow_id !== exp.result_flow_id) begin
        $display("%0t: flow id expected %h actual %h", $time, exp.result_flow_id,
                 got.result_flow_id);
        errors++;
      end
      if (got.grant_priority !== exp.grant_priority) begin
        $display("%0t: priority expected %0d actual %0d", $time, exp.grant_priority,
                 got.grant_priority);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last expected %b actual %b", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  grant_scoreboard sb = new();

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready && !rst) sb.check_result(rsp);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_ready <= 1'b0;
    end else if (!rsp_random) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= (gap_len() == 0);
    end
  end

  task automatic cfg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_HW_LEVELS) sb.hw_levels = val[3:0];
    else sb.unsch_levels = val[2:0];
  endtask

  task automatic send(logic [1:0] f, logic [15:0] id, logic [31:0] sz, logic [47:0] st,
                      bit gaps);
    req_t q;
    int g;
    q.func = f;
    q.flow_id = id;
    q.flow_size = sz;
    q.start_ticks = st;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= q;
    do @(posedge clk); while (!req_ready);
    sb.note_request(q);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    logic [1:0] f;
    r = $urandom_range(0, 99);
    if (r < 50) f = FUNC_ENQ;
    else if (r < 72) f = FUNC_DRAIN;
    else if (r < 97) f = FUNC_REMOVE;
    else f = FUNC_UNUSED;
    send(f, (r % 9 == 0) ? 16'($urandom) : 16'($urandom_range(0, key_space)),
         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20),
         ($urandom_range(0, 3) == 0) ? {16'($urandom), 32'($urandom)}
                                     : 48'($urandom_range(0, 5)), 1'b1);
  endtask

  initial begin
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    send(FUNC_DRAIN, 16'h0, 32'd0, 48'd0, 1'b0);
    send(FUNC_REMOVE, 16'hffff, 32'd0, 48'd0, 1'b0);
    send(FUNC_ENQ, 16'hffff, 32'hffffffff, 48'hffffffffffff, 1'b0);
    send(FUNC_ENQ, 16'h0000, 32'h0, 48'h0, 1'b0);
    send(FUNC_ENQ, 16'hffff, 32'h5, 48'h5, 1'b0);
    send(FUNC_ENQ, 16'h1234, 32'h0, 48'h0, 1'b0);
    send(FUNC_ENQ, 16'h5555, 32'h10, 48'h0, 1'b0);
    send(FUNC_ENQ, 16'haaaa, 32'h10, 48'h1, 1'b0);
    send(FUNC_UNUSED, 16'h1, 32'h1, 48'h1, 1'b0);
    send(FUNC_DRAIN, 16'h0, 32'd0, 48'd0, 1'b0);
    send(FUNC_ENQ, 16'hffff, 32'h1, 48'h1, 1'b0);
    send(FUNC_DRAIN, 16'h0, 32'd0, 48'd0, 1'b0);
    send(FUNC_REMOVE, 16'hffff, 32'd0, 48'd0, 1'b0);
    send(FUNC_REMOVE, 16'hffff, 32'd0, 48'd0, 1'b0);
    for (int i = 0; i < 17; i++)
      send(FUNC_ENQ, 16'(100 + i), 32'(i), 48'(i), 1'b0);
    send(FUNC_DRAIN, 16'h0, 32'd0, 48'd0, 1'b0);
    settle();

    // no available levels, then the widest setting
    cfg_write(REG_UNSCH_LEVELS, 32'd7);
    cfg_write(REG_HW_LEVELS, 32'd2);
    send(FUNC_DRAIN, 16'h0, 32'd0, 48'd0, 1'b0);
    settle();
    cfg_write(REG_HW_LEVELS, 32'd15);
    cfg_write(REG_UNSCH_LEVELS, 32'd1);

    // long result hold-off while requests keep coming
    hold_off <= 400;
    for (int i = 0; i < 40; i++) send_random();
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin cfg_write(REG_HW_LEVELS, 32'd8); cfg_write(REG_UNSCH_LEVELS, 32'd1); end
        1: begin cfg_write(REG_HW_LEVELS, 32'd4); cfg_write(REG_UNSCH_LEVELS, 32'd2); end
        2: begin cfg_write(REG_HW_LEVELS, 32'd2); cfg_write(REG_UNSCH_LEVELS, 32'd1); end
        default: begin
          cfg_write(REG_HW_LEVELS, 32'd15); cfg_write(REG_UNSCH_LEVELS, 32'd0);
        end
      endcase
      rsp_random = (ph != 1);
      key_space = (ph == 3) ? 60 : 30;
      for (int i = 0; i < 50; i++) send_random();
      settle();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #50000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
